// ===== rtl/tcr_pkg.sv =====
// ----------------------------------------------------------------------------
// tcr_pkg
// Types, constants and helper functions shared by the traceback run encoder.
// ----------------------------------------------------------------------------
package tcr_pkg;

  localparam logic [29:0] COUNT_MAX = 30'h3FFF_FFFF;
  localparam logic [15:0] RUNS_MAX  = 16'hFFFF;
  localparam logic [23:0] MISM_MAX  = 24'hFF_FFFF;

  // raw traceback op codes
  localparam logic [1:0] RAW_X = 2'd0;
  localparam logic [1:0] RAW_I = 2'd1;
  localparam logic [1:0] RAW_D = 2'd2;
  localparam logic [1:0] RAW_M = 2'd3;

  // mapped run op codes
  localparam logic [1:0] RUN_MATCH  = 2'd0;
  localparam logic [1:0] RUN_DELETE = 2'd2;
  localparam logic [1:0] RUN_INSERT = 2'd3;

  // results that one accepted byte can cause, in emission order
  typedef struct packed {
    logic        has_a;
    logic [31:0] word_a;
    logic        has_b;
    logic [31:0] word_b;
    logic        has_s;
    logic [15:0] word_total;
    logic [23:0] mismatch_total;
    logic [19:0] final_score;
    logic        overflowed;
  } entry_t;

  function automatic logic [1:0] map_op(input logic [1:0] raw);
    logic [1:0] op;
    unique case (raw)
      RAW_X:   op = RUN_MATCH;
      RAW_I:   op = RUN_INSERT;
      RAW_D:   op = RUN_DELETE;
      RAW_M:   op = RUN_MATCH;
      default: op = RUN_MATCH;
    endcase
    return op;
  endfunction

  function automatic logic [15:0] runs_inc(input logic [15:0] v);
    return (v == RUNS_MAX) ? v : v + 16'd1;
  endfunction

endpackage

// ===== rtl/tcr_if.sv =====
// ----------------------------------------------------------------------------
// tcr channel interfaces
// Traceback byte channel and cigar result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface trace_if;
  logic        valid;
  logic        ready;
  logic [1:0]  trace_op;
  logic [5:0]  trace_count_less_one;
  logic [19:0] alignment_score;
  logic        last_byte;

  modport source (
    output valid, trace_op, trace_count_less_one, alignment_score, last_byte,
    input  ready
  );
  modport sink (
    input  valid, trace_op, trace_count_less_one, alignment_score, last_byte,
    output ready
  );
endinterface

interface cigar_if;
  logic        valid;
  logic        ready;
  logic [31:0] cigar_word;
  logic        is_summary;
  logic [15:0] word_total;
  logic [23:0] mismatch_total;
  logic [19:0] final_score;
  logic        runs_overflowed;
  logic        last_result;

  modport source (
    output valid, cigar_word, is_summary, word_total, mismatch_total,
           final_score, runs_overflowed, last_result,
    input  ready
  );
  modport sink (
    input  valid, cigar_word, is_summary, word_total, mismatch_total,
           final_score, runs_overflowed, last_result,
    output ready
  );
endinterface

// ===== rtl/tcr_merge.sv =====
// ----------------------------------------------------------------------------
// tcr_merge
// Run merging, run and mismatch counting; builds one result entry per byte that causes a result.
// ----------------------------------------------------------------------------
module tcr_merge #(
  parameter int MAX_RUN_WORDS = 64
) (
  input  logic            clk,
  input  logic            rst,
  trace_if.sink           trace,
  input  logic            full,
  output logic            push,
  output tcr_pkg::entry_t entry
);

  localparam logic [15:0] RunLimit = 16'(MAX_RUN_WORDS);

  logic [1:0]  pending_op;
  logic [29:0] pending_count;
  logic [15:0] runs_so_far;
  logic [23:0] mismatches_so_far;
  logic        run_dropped;

  logic [1:0]  pending_op_next;
  logic [29:0] pending_count_next;
  logic [15:0] runs_so_far_next;
  logic [23:0] mismatches_so_far_next;
  logic        run_dropped_next;

  logic        acc;
  logic [1:0]  op;
  logic [6:0]  len;
  logic [30:0] sum;
  logic        cont;
  logic        close1;
  logic        room1;
  logic        room2;
  logic [15:0] runs1;
  logic [23:0] mism1;
  logic        drop1;
  logic        drop2;
  logic [29:0] cnt1;
  logic [15:0] runs2;

  assign trace.ready = !full;
  assign acc = trace.valid && trace.ready;

  always_comb begin
    op   = tcr_pkg::map_op(trace.trace_op);
    len  = {1'b0, trace.trace_count_less_one} + 7'd1;
    sum  = {1'b0, pending_count} + 31'(len);
    cont = (pending_count != '0) && (op == pending_op);

    mism1 = mismatches_so_far;
    if (trace.trace_op != tcr_pkg::RAW_M && mismatches_so_far != tcr_pkg::MISM_MAX) begin
      mism1 = mismatches_so_far + 24'd1;
    end

    // open run is closed by a byte of another op
    close1 = (pending_count != '0) && !cont;
    room1  = runs_so_far < RunLimit;
    runs1  = close1 ? tcr_pkg::runs_inc(runs_so_far) : runs_so_far;
    drop1  = run_dropped || (close1 && !room1);
    if (cont) begin
      cnt1 = sum[30] ? tcr_pkg::COUNT_MAX : sum[29:0];
    end else begin
      cnt1 = 30'(len);
    end

    // flush on the last byte
    room2 = runs1 < RunLimit;
    runs2 = tcr_pkg::runs_inc(runs1);
    drop2 = drop1 || !room2;

    entry.has_a          = close1 && room1;
    entry.word_a         = {pending_count, pending_op};
    entry.has_b          = trace.last_byte && room2;
    entry.word_b         = {cnt1, op};
    entry.has_s          = trace.last_byte;
    entry.word_total     = runs2;
    entry.mismatch_total = mism1;
    entry.final_score    = drop2 ? 20'd0 : trace.alignment_score;
    entry.overflowed     = drop2;

    push = acc && (entry.has_a || entry.has_s);

    if (trace.last_byte) begin
      pending_op_next        = '0;
      pending_count_next     = '0;
      runs_so_far_next       = '0;
      mismatches_so_far_next = '0;
      run_dropped_next       = 1'b0;
    end else begin
      pending_op_next        = op;
      pending_count_next     = cnt1;
      runs_so_far_next       = runs1;
      mismatches_so_far_next = mism1;
      run_dropped_next       = drop1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_op        <= '0;
      pending_count     <= '0;
      runs_so_far       <= '0;
      mismatches_so_far <= '0;
      run_dropped       <= 1'b0;
    end else if (acc) begin
      pending_op        <= pending_op_next;
      pending_count     <= pending_count_next;
      runs_so_far       <= runs_so_far_next;
      mismatches_so_far <= mismatches_so_far_next;
      run_dropped       <= run_dropped_next;
    end
  end

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (acc && trace.last_byte) |=> (pending_count == '0 && runs_so_far == '0))
    else $error("state not cleared after last byte");

  a_last_pushes: assert property (@(posedge clk) disable iff (rst)
    (acc && trace.last_byte) |-> (push && entry.has_s))
    else $error("last byte did not push a summary");

endmodule

// ===== rtl/tcr_fifo.sv =====
// ----------------------------------------------------------------------------
// tcr_fifo
// Two-entry buffer of result entries between merging and emission.
// ----------------------------------------------------------------------------
module tcr_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  tcr_pkg::entry_t wr_entry,
  input  logic            pop,
  output tcr_pkg::entry_t head,
  output logic            empty,
  output logic            full
);

  tcr_pkg::entry_t slots [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;

  assign empty = (count == 2'd0);
  assign full  = (count == 2'd2);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (push |-> !full) and (pop |-> !empty))
    else $error("buffer overrun or underrun");

endmodule

// ===== rtl/tcr_emit.sv =====
// ----------------------------------------------------------------------------
// tcr_emit
// Steps through the results held in the head entry, one item per handshake.
// ----------------------------------------------------------------------------
module tcr_emit (
  input  logic            clk,
  input  logic            rst,
  input  tcr_pkg::entry_t head,
  input  logic            empty,
  output logic            pop,
  cigar_if.source         cigar
);

  logic [2:0] done;
  logic [2:0] done_next;
  logic [2:0] avail;
  logic [2:0] cur;
  logic       acc;

  always_comb begin
    avail = {head.has_s, head.has_b, head.has_a} & ~done;
    // first outstanding result wins: run a, run b, then summary
    priority if (avail[0]) begin
      cur = 3'b001;
    end else if (avail[1]) begin
      cur = 3'b010;
    end else if (avail[2]) begin
      cur = 3'b100;
    end else begin
      cur = 3'b000;
    end

    cigar.valid           = !empty;
    cigar.cigar_word      = cur[0] ? head.word_a : (cur[1] ? head.word_b : 32'd0);
    cigar.is_summary      = cur[2];
    cigar.word_total      = cur[2] ? head.word_total : 16'd0;
    cigar.mismatch_total  = cur[2] ? head.mismatch_total : 24'd0;
    cigar.final_score     = cur[2] ? head.final_score : 20'd0;
    cigar.runs_overflowed = cur[2] && head.overflowed;
    cigar.last_result     = cur[2];

    acc = cigar.valid && cigar.ready;
    pop = acc && ((avail & ~cur) == 3'b000);
    if (pop) begin
      done_next = 3'b000;
    end else if (acc) begin
      done_next = done | cur;
    end else begin
      done_next = done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 3'b000;
    end else begin
      done <= done_next;
    end
  end

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    cigar.valid |-> $onehot(cur))
    else $error("head entry has no outstanding result");

endmodule

// ===== rtl/traceback_to_cigar_runs.sv =====
// ----------------------------------------------------------------------------
// traceback_to_cigar_runs
// Each result item is registered in a two-entry result buffer before it leaves.
// Throughput: one byte per cycle while the sink is ready and each byte causes at
// most one result; the last byte of an alignment causes up to three, sent one per
// cycle while the sink is ready. Reset clears the open run, counters and buffer.
// ----------------------------------------------------------------------------
module traceback_to_cigar_runs #(
  parameter int MAX_RUN_WORDS = 64
) (
  input  logic    clk,
  input  logic    rst,
  trace_if.sink   trace,
  cigar_if.source cigar
);

  tcr_pkg::entry_t wr_entry;
  tcr_pkg::entry_t head;
  logic            push;
  logic            pop;
  logic            empty;
  logic            full;

  tcr_merge #(
    .MAX_RUN_WORDS (MAX_RUN_WORDS)
  ) u_merge (
    .clk   (clk),
    .rst   (rst),
    .trace (trace),
    .full  (full),
    .push  (push),
    .entry (wr_entry)
  );

  tcr_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (wr_entry),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full)
  );

  tcr_emit u_emit (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .empty (empty),
    .pop   (pop),
    .cigar (cigar)
  );

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench for traceback_to_cigar_runs. A short table of directed bytes comes
// first, then alignments at and just past the run limit and random alignments
// under three back-pressure patterns. Each result item is checked against a run
// encoder in the bench, or for typed rows against values written by hand.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_WORDS   = 64;
  localparam int STALL_LIMIT = 2000;
  localparam int PLAN_ROWS   = 15;

  typedef struct packed {
    logic [31:0] word;
    logic        summ;
    logic [15:0] runs;
    logic [23:0] mism;
    logic [19:0] score;
    logic        ovf;
    logic        lastr;
  } cigar_res_t;

  // one traceback byte; typed rows carry the run word and summary by hand
  typedef struct packed {
    logic [1:0]  op;
    logic [5:0]  len_m1;
    logic [19:0] score;
    logic        lst;
    logic        typed;
    logic [31:0] t_word;
    logic [23:0] t_mism;
    logic [19:0] t_score;
  } trace_row_t;

  logic clk;
  logic rst;

  trace_if trace ();
  cigar_if cigar ();

  traceback_to_cigar_runs #(
    .MAX_RUN_WORDS(MAX_WORDS)
  ) u_top (
    .clk  (clk),
    .rst  (rst),
    .trace(trace),
    .cigar(cigar)
  );

  // encoder state kept by the bench
  logic [1:0]  run_op;
  logic [29:0] run_len;
  logic [15:0] run_tally;
  logic [23:0] mism_tally;
  logic        run_dropped;

  cigar_res_t fresh[$];
  cigar_res_t pending_cigars[$];

  int fail_count   = 0;
  int bytes_sent   = 0;
  int stall_cycles = 0;
  int src_idle;
  int snk_idle;

  trace_row_t plan [PLAN_ROWS] = '{
    // single-byte alignments from a clean state
    '{tcr_pkg::RAW_M, 6'd63, 20'hFFFFF, 1'b1, 1'b1, 32'h100, 24'd0, 20'hFFFFF},
    '{tcr_pkg::RAW_X, 6'd0,  20'h00000, 1'b1, 1'b1, 32'h004, 24'd1, 20'h00000},
    '{tcr_pkg::RAW_I, 6'd0,  20'h5A5A5, 1'b1, 1'b1, 32'h007, 24'd1, 20'h5A5A5},
    '{tcr_pkg::RAW_D, 6'd63, 20'h00001, 1'b1, 1'b1, 32'h102, 24'd1, 20'h00001},
    // x and m merge, then insert and delete runs, last byte extends the run
    '{tcr_pkg::RAW_X, 6'd5,  20'h00000, 1'b0, 1'b0, 32'h0, 24'd0, 20'h0},
    '{tcr_pkg::RAW_M, 6'd10, 20'h00000, 1'b0, 1'b0, 32'h0, 24'd0, 20'h0},
    '{tcr_pkg::RAW_M, 6'd63, 20'h00000, 1'b0, 1'b0, 32'h0, 24'd0, 20'h0},
    '{tcr_pkg::RAW_I, 6'd2,  20'h00000, 1'b0, 1'b0, 32'h0, 24'd0, 20'h0},
    '{tcr_pkg::RAW_I, 6'd3,  20'h00000, 1'b0, 1'b0, 32'h0, 24'd0, 20'h0},
    '{tcr_pkg::RAW_D, 6'd0,  20'h00000, 1'b0, 1'b0, 32'h0, 24'd0, 20'h0},
    '{tcr_pkg::RAW_X, 6'd0,  20'h00000, 1'b0, 1'b0, 32'h0, 24'd0, 20'h0},
    '{tcr_pkg::RAW_D, 6'd1,  20'h00000, 1'b0, 1'b0, 32'h0, 24'd0, 20'h0},
    '{tcr_pkg::RAW_D, 6'd2,  20'hABCDE, 1'b1, 1'b0, 32'h0, 24'd0, 20'h0},
    // last byte opens a new run: two words and the summary
    '{tcr_pkg::RAW_I, 6'd7,  20'h00000, 1'b0, 1'b0, 32'h0, 24'd0, 20'h0},
    '{tcr_pkg::RAW_M, 6'd0,  20'h12345, 1'b1, 1'b0, 32'h0, 24'd0, 20'h0}
  };

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [1:0] run_code(input logic [1:0] raw);
    case (raw)
      tcr_pkg::RAW_I: return tcr_pkg::RUN_INSERT;
      tcr_pkg::RAW_D: return tcr_pkg::RUN_DELETE;
      default:        return tcr_pkg::RUN_MATCH;
    endcase
  endfunction

  function automatic void clear_runs();
    run_op      = tcr_pkg::RUN_MATCH;
    run_len     = '0;
    run_tally   = '0;
    mism_tally  = '0;
    run_dropped = 1'b0;
  endfunction

  // counts the open run, emits it only below the word limit
  function automatic void close_run();
    cigar_res_t r;
    if (run_tally < MAX_WORDS) begin
      r = '0;
      r.word = {run_len, run_op};
      fresh = {fresh, r};
    end else begin
      run_dropped = 1'b1;
    end
    if (run_tally != tcr_pkg::RUNS_MAX) run_tally = run_tally + 16'd1;
  endfunction

  function automatic void encode_byte(input trace_row_t b);
    logic [1:0]  code;
    logic [30:0] grown;
    cigar_res_t  s;
    code = run_code(b.op);
    if (b.op != tcr_pkg::RAW_M && mism_tally != tcr_pkg::MISM_MAX) begin
      mism_tally = mism_tally + 24'd1;
    end
    if (run_len != '0 && code == run_op) begin
      grown   = {1'b0, run_len} + 31'(b.len_m1) + 31'd1;
      run_len = (grown > 31'(tcr_pkg::COUNT_MAX)) ? tcr_pkg::COUNT_MAX : grown[29:0];
    end else begin
      if (run_len != '0) close_run();
      run_op  = code;
      run_len = 30'(b.len_m1) + 30'd1;
    end
    if (b.lst) begin
      if (run_len != '0) close_run();
      s       = '0;
      s.summ  = 1'b1;
      s.runs  = run_tally;
      s.mism  = mism_tally;
      s.score = run_dropped ? 20'd0 : b.score;
      s.ovf   = run_dropped;
      s.lastr = 1'b1;
      fresh = {fresh, s};
      clear_runs();
    end
  endfunction

  task automatic send_byte(input trace_row_t b);
    cigar_res_t r;
    while ($urandom_range(99) < src_idle) begin
      trace.valid <= 1'b0;
      @(posedge clk);
    end
    trace.valid                <= 1'b1;
    trace.trace_op             <= b.op;
    trace.trace_count_less_one <= b.len_m1;
    trace.alignment_score      <= b.score;
    trace.last_byte            <= b.lst;
    @(posedge clk);
    while (!trace.ready) @(posedge clk);
    fresh.delete();
    encode_byte(b);
    if (b.typed) begin
      r = '0;
      r.word = b.t_word;
      pending_cigars = {pending_cigars, r};
      r       = '0;
      r.summ  = 1'b1;
      r.runs  = 16'd1;
      r.mism  = b.t_mism;
      r.score = b.t_score;
      r.lastr = 1'b1;
      pending_cigars = {pending_cigars, r};
    end else begin
      pending_cigars = {pending_cigars, fresh};
    end
    bytes_sent++;
  endtask

  // every_new forces each byte to open a run of its own
  task automatic send_alignment(input int n, input bit every_new);
    trace_row_t b;
    logic [1:0] prev;
    b    = '0;
    prev = tcr_pkg::RAW_M;
    for (int i = 0; i < n; i++) begin
      b.op = 2'($urandom_range(3));
      if (i > 0) begin
        if (every_new) begin
          while (run_code(b.op) == run_code(prev)) b.op = 2'($urandom_range(3));
        end else if ($urandom_range(2) == 0) begin
          b.op = prev;
        end
      end
      b.len_m1 = 6'($urandom_range(63));
      b.score  = 20'($urandom_range(20'hFFFFF));
      b.lst    = (i == n - 1);
      send_byte(b);
      prev = b.op;
    end
  endtask

  task automatic random_alignments(input int n_bytes);
    int stop;
    stop = bytes_sent + n_bytes;
    // mostly short alignments, now and then a longer one
    while (bytes_sent < stop) begin
      if ($urandom_range(5) == 0) send_alignment($urandom_range(12, 6), 1'b0);
      else send_alignment($urandom_range(6, 1), 1'b0);
    end
  endtask

  initial begin
    rst                        = 1'b1;
    trace.valid                = 1'b0;
    trace.trace_op             = tcr_pkg::RAW_X;
    trace.trace_count_less_one = '0;
    trace.alignment_score      = '0;
    trace.last_byte            = 1'b0;
    src_idle                   = 30;
    snk_idle                   = 79;
    clear_runs();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < PLAN_ROWS; i++) send_byte(plan[i]);
    // exactly at the word limit
    send_alignment(MAX_WORDS, 1'b1);
    random_alignments(15);

    src_idle = 79;
    snk_idle = 30;
    // one run past the word limit
    send_alignment(MAX_WORDS + 1, 1'b1);
    random_alignments(15);

    src_idle = 0;
    snk_idle = 0;
    random_alignments(30);

    trace.valid <= 1'b0;
    while (pending_cigars.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  always @(posedge clk) begin
    cigar.ready <= ($urandom_range(99) >= snk_idle);
  end

  function automatic void check_field(input string what, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch: expected %0h, got %0h", $time, what, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    cigar_res_t seen;
    cigar_res_t want;
    if (!rst && cigar.valid && cigar.ready) begin
      seen = {cigar.cigar_word, cigar.is_summary, cigar.word_total, cigar.mismatch_total,
              cigar.final_score, cigar.runs_overflowed, cigar.last_result};
      if (pending_cigars.size() == 0) begin
        $display("%0t ns: result item with nothing expected: expected none, got %h",
                 $time, seen);
        fail_count++;
      end else begin
        want = pending_cigars.pop_front();
        check_field("cigar_word", want.word, seen.word);
        check_field("is_summary", 32'(want.summ), 32'(seen.summ));
        check_field("word_total", 32'(want.runs), 32'(seen.runs));
        check_field("mismatch_total", 32'(want.mism), 32'(seen.mism));
        check_field("final_score", 32'(want.score), 32'(seen.score));
        check_field("runs_overflowed", 32'(want.ovf), 32'(seen.ovf));
        check_field("last_result", 32'(want.lastr), 32'(seen.lastr));
      end
    end
  end

  // watchdog on cycles with no item moving on either channel
  always @(posedge clk) begin
    if (rst || (trace.valid && trace.ready) || (cigar.valid && cigar.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule
